// File: design/assert_macros.svh
// Assertion macros shared by the management master modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that a condition never holds.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: design/mdio_mm_pkg.sv
// Types and constants of the MDIO management master.
package mdio_mm_pkg;

	localparam int unsigned PreambleBitsDefault = 32;
	localparam int unsigned PhyAddrW = 5;
	localparam int unsigned RegAddrW = 5;
	localparam int unsigned DataW = 16;
	localparam int unsigned BitPosW = 6;
	localparam int unsigned FrameW = 32;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 5;

	localparam logic [CfgIdxW-1:0] CFG_PHY_ADDRESS = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_PREAMBLE_ENABLE = 1'd1;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [1:0] FRAME_START = 2'b01;
	localparam logic [1:0] OPCODE_WRITE = 2'b01;
	localparam logic [1:0] OPCODE_READ = 2'b10;
	localparam logic [1:0] TURNAROUND = 2'b10;

	localparam logic [PhyAddrW-1:0] PhyAddressReset = 5'd1;
	localparam logic PreambleEnableReset = 1'b1;

	typedef struct packed {
		logic mode;
		logic is_read;
		logic [RegAddrW-1:0] reg_address;
		logic [DataW-1:0] write_data;
		logic mdio_in;
	} cmd_t;

	typedef struct packed {
		logic mdio_out;
		logic mdio_drive;
		logic idle;
		logic frame_done;
		logic [DataW-1:0] read_data;
		logic start_rejected;
	} rsp_t;

	typedef struct packed {
		logic [PhyAddrW-1:0] phy_address;
		logic preamble_enable;
	} cfg_t;

endpackage

// File: design/mdio_mm_if.sv
// Valid/ready channel interfaces for commands and responses.
interface mdio_mm_cmd_if;
	logic valid;
	logic ready;
	mdio_mm_pkg::cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mdio_mm_rsp_if;
	logic valid;
	logic ready;
	mdio_mm_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: design/mdio_mm_engine.sv
// Frame state and per-item next-state and response logic.
`include "assert_macros.svh"

module mdio_mm_engine #(
	parameter int unsigned PreambleBits = mdio_mm_pkg::PreambleBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  mdio_mm_pkg::cfg_t cfg,
	input  logic accept,
	input  mdio_mm_pkg::cmd_t cmd,
	output mdio_mm_pkg::rsp_t rsp
);

	localparam logic [mdio_mm_pkg::BitPosW-1:0] StartLong =
		mdio_mm_pkg::BitPosW'(PreambleBits + mdio_mm_pkg::FrameW - 1);
	localparam logic [mdio_mm_pkg::BitPosW-1:0] StartShort =
		mdio_mm_pkg::BitPosW'(mdio_mm_pkg::FrameW - 1);
	localparam logic [mdio_mm_pkg::BitPosW-1:0] LastTaBit =
		mdio_mm_pkg::BitPosW'(mdio_mm_pkg::DataW + 1);
	localparam logic [mdio_mm_pkg::BitPosW-1:0] LastDataBit =
		mdio_mm_pkg::BitPosW'(mdio_mm_pkg::DataW - 1);

	logic [mdio_mm_pkg::FrameW-1:0] frame_q, frame_d;
	logic [mdio_mm_pkg::BitPosW-1:0] bitpos_q, bitpos_d;
	logic busy_q, busy_d;
	logic read_q, read_d;
	logic [mdio_mm_pkg::DataW-1:0] cap_q, cap_d;
	logic level, drive, done, rejected;

	always_comb begin
		frame_d = frame_q;
		bitpos_d = bitpos_q;
		busy_d = busy_q;
		read_d = read_q;
		cap_d = cap_q;
		level = 1'b0;
		drive = 1'b0;
		done = 1'b0;
		rejected = 1'b0;
		if (accept) begin
			if (cmd.mode == mdio_mm_pkg::MODE_START) begin
				if (busy_q) begin
					rejected = 1'b1;
				end else begin
					frame_d = {mdio_mm_pkg::FRAME_START,
						cmd.is_read ? mdio_mm_pkg::OPCODE_READ : mdio_mm_pkg::OPCODE_WRITE,
						cfg.phy_address, cmd.reg_address, mdio_mm_pkg::TURNAROUND,
						cmd.is_read ? {mdio_mm_pkg::DataW{1'b0}} : cmd.write_data};
					read_d = cmd.is_read;
					bitpos_d = cfg.preamble_enable ? StartLong : StartShort;
					busy_d = 1'b1;
				end
			end else if (busy_q) begin
				if (bitpos_q[mdio_mm_pkg::BitPosW-1]) begin
					level = 1'b1;
					drive = 1'b1;
				end else if (read_q && bitpos_q <= LastTaBit) begin
					if (bitpos_q <= LastDataBit) begin
						frame_d[bitpos_q[3:0]] = cmd.mdio_in;
					end
				end else begin
					level = frame_q[bitpos_q[4:0]];
					drive = 1'b1;
				end
				if (bitpos_q == '0) begin
					done = 1'b1;
					busy_d = 1'b0;
					if (read_q) begin
						cap_d = frame_d[mdio_mm_pkg::DataW-1:0];
					end
				end else begin
					bitpos_d = bitpos_q - 1'b1;
				end
			end
		end
	end

	always_comb begin
		rsp.mdio_out = level;
		rsp.mdio_drive = drive;
		rsp.idle = !busy_d;
		rsp.frame_done = done;
		rsp.read_data = cap_d;
		rsp.start_rejected = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			bitpos_q <= '0;
			busy_q <= 1'b0;
			read_q <= 1'b0;
			cap_q <= '0;
		end else begin
			frame_q <= frame_d;
			bitpos_q <= bitpos_d;
			busy_q <= busy_d;
			read_q <= read_d;
			cap_q <= cap_d;
		end
	end

	`ASSERT_CLK(a_bitpos_range, busy_q |-> bitpos_q <= StartLong, "bit position out of range")
	`ASSERT_CLK(a_last_tick_ends, (accept && cmd.mode == mdio_mm_pkg::MODE_TICK && busy_q && bitpos_q == '0) |=> !busy_q, "frame did not end on last bit")

endmodule

// File: design/mdio_mm_rsp_buf.sv
// Two-entry response register with skid stage.
`include "assert_macros.svh"

module mdio_mm_rsp_buf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  mdio_mm_pkg::rsp_t push_data,
	output logic ready,
	mdio_mm_rsp_if.source rsp
);

	mdio_mm_pkg::rsp_t main_q, skid_q;
	logic main_valid_q, skid_valid_q;
	logic pop;

	assign ready = !skid_valid_q;
	assign pop = main_valid_q && rsp.ready;
	assign rsp.valid = main_valid_q;
	assign rsp.payload = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop && skid_valid_q) begin
			skid_valid_q <= 1'b0;
		end else if (pop || !main_valid_q) begin
			main_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end else if (pop || !main_valid_q) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`ASSERT_CLK(a_skid_behind_main, skid_valid_q |-> main_valid_q, "skid holds data ahead of main")
	`ASSERT_CLK(a_stall_fills_skid, (main_valid_q && !rsp.ready && push) |=> skid_valid_q, "stalled transfer lost")

endmodule

// File: design/mdio_management_master.sv
// MDIO Clause 22 management master: one transfer in, one response out, every
// cycle while not stalled. Each accepted item (a start or one MDC bit tick) is handled by
// the frame engine in the cycle it is accepted and its response lands in a two-entry output
// register, so a new item is taken each cycle as long as the response side
// keeps up; ready drops only while both response entries are full. A frame
// takes one tick per bit: 32 bits, plus PreambleBits ones when preamble is
// enabled. Configuration writes take effect on the next start.
module mdio_management_master #(
	parameter int unsigned PreambleBits = mdio_mm_pkg::PreambleBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mdio_mm_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [mdio_mm_pkg::CfgDataW-1:0] cfg_wdata,
	mdio_mm_cmd_if.sink cmd,
	mdio_mm_rsp_if.source rsp
);

	mdio_mm_pkg::cfg_t cfg_q;
	mdio_mm_pkg::rsp_t step_rsp;
	logic accept;
	logic buf_ready;

	assign cmd.ready = buf_ready;
	assign accept = cmd.valid && buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phy_address <= mdio_mm_pkg::PhyAddressReset;
			cfg_q.preamble_enable <= mdio_mm_pkg::PreambleEnableReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mdio_mm_pkg::CFG_PHY_ADDRESS: begin
					cfg_q.phy_address <= cfg_wdata[mdio_mm_pkg::PhyAddrW-1:0];
				end
				mdio_mm_pkg::CFG_PREAMBLE_ENABLE: begin
					cfg_q.preamble_enable <= cfg_wdata[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	mdio_mm_engine #(
		.PreambleBits(PreambleBits)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.accept(accept),
		.cmd(cmd.payload),
		.rsp(step_rsp)
	);

	mdio_mm_rsp_buf u_rsp_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_data(step_rsp),
		.ready(buf_ready),
		.rsp(rsp)
	);

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the MDIO management master: frame, preamble, read and busy cases.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LINE_LOW = 0;
	localparam int LINE_HIGH = 1;
	localparam int LINE_RANDOM = 2;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mdio_mm_pkg::CfgIdxW-1:0] cfg_index;
	logic [mdio_mm_pkg::CfgDataW-1:0] cfg_wdata;

	mdio_mm_cmd_if cmd_ch ();
	mdio_mm_rsp_if rsp_ch ();

	mdio_management_master u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// Master state mirror
	logic [mdio_mm_pkg::PhyAddrW-1:0] cfg_phy = mdio_mm_pkg::PhyAddressReset;
	logic cfg_pre = mdio_mm_pkg::PreambleEnableReset;
	logic [mdio_mm_pkg::FrameW-1:0] frame_sr = '0;
	logic [mdio_mm_pkg::BitPosW-1:0] bits_left = '0;
	logic frame_busy = 1'b0;
	logic rd_op = 1'b0;
	logic [mdio_mm_pkg::DataW-1:0] rd_capture = '0;

	mdio_mm_pkg::rsp_t line_status_q[$];
	int mismatches = 0;
	int rsp_count = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic mdio_mm_pkg::rsp_t mdc_step(mdio_mm_pkg::cmd_t c);
		mdio_mm_pkg::rsp_t r;
		logic [mdio_mm_pkg::BitPosW-1:0] pos;
		r = '0;
		if (c.mode == mdio_mm_pkg::MODE_START) begin
			if (frame_busy) begin
				r.start_rejected = 1'b1;
			end else begin
				frame_sr = {mdio_mm_pkg::FRAME_START,
					c.is_read ? mdio_mm_pkg::OPCODE_READ : mdio_mm_pkg::OPCODE_WRITE,
					cfg_phy, c.reg_address, mdio_mm_pkg::TURNAROUND,
					c.is_read ? {mdio_mm_pkg::DataW{1'b0}} : c.write_data};
				rd_op = c.is_read;
				bits_left = cfg_pre
					? mdio_mm_pkg::BitPosW'(mdio_mm_pkg::PreambleBitsDefault
						+ mdio_mm_pkg::FrameW - 1)
					: mdio_mm_pkg::BitPosW'(mdio_mm_pkg::FrameW - 1);
				frame_busy = 1'b1;
			end
		end else if (frame_busy) begin
			pos = bits_left;
			if (pos >= mdio_mm_pkg::FrameW) begin
				r.mdio_out = 1'b1;
				r.mdio_drive = 1'b1;
			end else if (rd_op && pos <= mdio_mm_pkg::DataW + 1) begin
				if (pos < mdio_mm_pkg::DataW)
					frame_sr[pos[4:0]] = c.mdio_in;
			end else begin
				r.mdio_out = frame_sr[pos[4:0]];
				r.mdio_drive = 1'b1;
			end
			if (pos == 0) begin
				r.frame_done = 1'b1;
				frame_busy = 1'b0;
				if (rd_op)
					rd_capture = frame_sr[mdio_mm_pkg::DataW-1:0];
			end else begin
				bits_left = pos - 1'b1;
			end
		end
		r.idle = !frame_busy;
		r.read_data = rd_capture;
		return r;
	endfunction

	function automatic mdio_mm_pkg::cmd_t rand_cmd(logic mode);
		mdio_mm_pkg::cmd_t c;
		logic [31:0] bits;
		bits = $urandom;
		c = bits[$bits(mdio_mm_pkg::cmd_t)-1:0];
		c.mode = mode;
		return c;
	endfunction

	function automatic mdio_mm_pkg::cmd_t start_cmd(logic rd,
		logic [mdio_mm_pkg::RegAddrW-1:0] ra, logic [mdio_mm_pkg::DataW-1:0] wd);
		mdio_mm_pkg::cmd_t c;
		c = rand_cmd(mdio_mm_pkg::MODE_START);
		c.is_read = rd;
		c.reg_address = ra;
		c.write_data = wd;
		return c;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_line_status(mdio_mm_pkg::rsp_t got);
		mdio_mm_pkg::rsp_t want;
		if (line_status_q.size() == 0) begin
			report_mismatch($sformatf("response %0d arrived with none pending: %h",
				rsp_count, got));
			return;
		end
		want = line_status_q.pop_front();
		if (got.mdio_out !== want.mdio_out)
			report_mismatch($sformatf("response %0d mdio_out %b, want %b",
				rsp_count, got.mdio_out, want.mdio_out));
		if (got.mdio_drive !== want.mdio_drive)
			report_mismatch($sformatf("response %0d mdio_drive %b, want %b",
				rsp_count, got.mdio_drive, want.mdio_drive));
		if (got.idle !== want.idle)
			report_mismatch($sformatf("response %0d idle %b, want %b",
				rsp_count, got.idle, want.idle));
		if (got.frame_done !== want.frame_done)
			report_mismatch($sformatf("response %0d frame_done %b, want %b",
				rsp_count, got.frame_done, want.frame_done));
		if (got.read_data !== want.read_data)
			report_mismatch($sformatf("response %0d read_data %h, want %h",
				rsp_count, got.read_data, want.read_data));
		if (got.start_rejected !== want.start_rejected)
			report_mismatch($sformatf("response %0d start_rejected %b, want %b",
				rsp_count, got.start_rejected, want.start_rejected));
	endtask

	// Receiver: check each transfer, then choose ready for the next edge
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				check_line_status(rsp_ch.payload);
				rsp_count++;
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[%0t] no transfer for %0d cycles", $realtime, stall_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(mdio_mm_pkg::cmd_t c);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= c;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		line_status_q.push_back(mdc_step(c));
	endtask

	task automatic tick_until_idle(int line_sel);
		mdio_mm_pkg::cmd_t c;
		while (frame_busy) begin
			c = rand_cmd(mdio_mm_pkg::MODE_TICK);
			if (line_sel == LINE_LOW)
				c.mdio_in = 1'b0;
			else if (line_sel == LINE_HIGH)
				c.mdio_in = 1'b1;
			send_item(c);
		end
	endtask

	// Finish any frame, then hold the sender until every response is back
	task automatic drain_and_idle();
		tick_until_idle(LINE_RANDOM);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (line_status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [mdio_mm_pkg::CfgIdxW-1:0] idx,
		logic [mdio_mm_pkg::CfgDataW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx == mdio_mm_pkg::CFG_PHY_ADDRESS)
			cfg_phy = value[mdio_mm_pkg::PhyAddrW-1:0];
		else
			cfg_pre = value[0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		mdio_mm_pkg::cmd_t c;
		c = rand_cmd(mdio_mm_pkg::MODE_TICK);
		c.mdio_in = 1'b1;
		send_item(c);
		c = rand_cmd(mdio_mm_pkg::MODE_TICK);
		c.mdio_in = 1'b0;
		send_item(c);
		send_item(start_cmd(1'b0, '0, '1));
		repeat (5) send_item(rand_cmd(mdio_mm_pkg::MODE_TICK));
		send_item(start_cmd(1'b1, '1, '0));
		tick_until_idle(LINE_RANDOM);
		send_item(start_cmd(1'b1, '1, mdio_mm_pkg::DataW'($urandom)));
		tick_until_idle(LINE_HIGH);
	endtask

	task automatic test_config_extremes();
		drain_and_idle();
		write_cfg(mdio_mm_pkg::CFG_PHY_ADDRESS, '1);
		write_cfg(mdio_mm_pkg::CFG_PREAMBLE_ENABLE, {4'($urandom_range(0, 15)), 1'b0});
		send_item(start_cmd(1'b0, '1, '0));
		tick_until_idle(LINE_RANDOM);
		send_item(start_cmd(1'b1, '0, mdio_mm_pkg::DataW'($urandom)));
		send_item(start_cmd(1'b0, mdio_mm_pkg::RegAddrW'($urandom),
			mdio_mm_pkg::DataW'($urandom)));
		tick_until_idle(LINE_LOW);
	endtask

	task automatic test_random_traffic(int n_items, int snd_pct, int rcv_pct,
		logic [mdio_mm_pkg::PhyAddrW-1:0] phy, logic pre);
		int counted;
		mdio_mm_pkg::cmd_t c;
		drain_and_idle();
		write_cfg(mdio_mm_pkg::CFG_PHY_ADDRESS, mdio_mm_pkg::CfgDataW'(phy));
		write_cfg(mdio_mm_pkg::CFG_PREAMBLE_ENABLE, {4'($urandom_range(0, 15)), pre});
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		counted = 0;
		while (counted < n_items) begin
			if (frame_busy) begin
				c = rand_cmd(($urandom_range(0, 99) < 97) ? mdio_mm_pkg::MODE_TICK
					: mdio_mm_pkg::MODE_START);
				if (c.mode == mdio_mm_pkg::MODE_TICK)
					counted++;
			end else begin
				c = rand_cmd(($urandom_range(0, 99) < 80) ? mdio_mm_pkg::MODE_START
					: mdio_mm_pkg::MODE_TICK);
				if (c.mode == mdio_mm_pkg::MODE_START)
					counted++;
			end
			send_item(c);
		end
	endtask

	task automatic test_backpressure();
		drain_and_idle();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_request = 300;
		send_item(rand_cmd(mdio_mm_pkg::MODE_START));
		send_item(rand_cmd(mdio_mm_pkg::MODE_START));
		tick_until_idle(LINE_RANDOM);
		drain_and_idle();
		hold_request = 120;
		repeat (6) send_item(rand_cmd(mdio_mm_pkg::MODE_TICK));
		send_item(rand_cmd(mdio_mm_pkg::MODE_START));
		tick_until_idle(LINE_RANDOM);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mdio_mm_pkg::CFG_PHY_ADDRESS;
		cfg_wdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.payload <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 26;
		rcv_idle_pct = 49;
		test_reset_defaults();
		test_config_extremes();
		test_random_traffic(160, 26, 49, '1, 1'b1);
		test_random_traffic(160, 49, 26, '0, 1'b0);
		test_random_traffic(160, 0, 0, mdio_mm_pkg::PhyAddrW'($urandom_range(0, 31)),
			1'($urandom_range(0, 1)));
		test_backpressure();
		drain_and_idle();

		if (line_status_q.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", line_status_q.size()));
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
